@@ src/rwr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the RDMA WRITE responder.
// No dependencies; every other file refers to this package by scoped names.

package rwr_pkg;

    localparam int QP_W        = 8;
    localparam int QP_COUNT    = 1 << QP_W;
    localparam int LEN_W       = 13;
    localparam int MAX_PAYLOAD = 4096;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    localparam logic [7:0] OP_WR_FIRST    = 8'd6;
    localparam logic [7:0] OP_WR_MIDDLE   = 8'd7;
    localparam logic [7:0] OP_WR_LAST     = 8'd8;
    localparam logic [7:0] OP_WR_LAST_IMM = 8'd9;
    localparam logic [7:0] OP_WR_ONLY     = 8'd10;
    localparam logic [7:0] OP_WR_ONLY_IMM = 8'd11;

    localparam logic [2:0] SYN_NONE    = 3'd0;
    localparam logic [2:0] SYN_ACK     = 3'd1;
    localparam logic [2:0] SYN_PSN_ERR = 3'd2;
    localparam logic [2:0] SYN_INV_REQ = 3'd3;
    localparam logic [2:0] SYN_ACC_ERR = 3'd4;
    localparam logic [2:0] SYN_RNR_NAK = 3'd5;

    localparam int ST_KEY_REJ = 0;
    localparam int ST_PAY_REJ = 1;

    typedef struct packed {
        logic [7:0]       qp_index;
        logic [7:0]       opcode;
        logic [23:0]      psn;
        logic             ack_req;
        logic             reth_valid;
        logic [63:0]      reth_address;
        logic [1:0]       access_status;
        logic [LEN_W-1:0] payload_length;
        logic [31:0]      imm_word;
        logic             qp_can_receive;
        logic [23:0]      qp_epsn;
        logic             recv_wqe_available;
    } req_t;

    typedef struct packed {
        logic        ignored;
        logic        accepted;
        logic        ack_needed;
        logic [2:0]  syndrome;
        logic [23:0] ack_psn;
        logic        write_enable;
        logic [63:0] write_address;
        logic        advance_qp_psn;
        logic        message_complete;
        logic        cqe_valid;
        logic [31:0] cqe_bytes;
        logic [31:0] cqe_immediate;
    } rsp_t;

    typedef struct packed {
        logic        active;
        logic [63:0] base_address;
        logic [31:0] byte_count;
        logic [23:0] next_psn;
        logic        imm_seen;
        logic [31:0] immediate;
    } ctx_t;

    typedef struct packed {
        logic            en;
        logic [QP_W-1:0] addr;
        ctx_t            data;
    } ctx_wr_t;

endpackage

@@ src/rdma_write_responder.sv @@
`timescale 1ns / 1ps
// Top level of the RDMA WRITE responder: command handshake, sequencer, result register.
// Depends on rwr_pkg, rwr_ctx_store and rwr_engine.
//
// Usage:
//   Drive one parsed write header on req and raise start. The item is taken at
//   a rising edge where start is high and busy is low. busy then stays high
//   for one cycle while the queue pair context is read from the context
//   memory, checked and written back.
//   Exactly one result per item appears on rsp with rsp_valid high for one
//   cycle: rsp_valid rises at the edge after the accepting edge. The receiver
//   cannot stall: take rsp in that cycle.
//   A new item is not taken while busy is high: the context memory read is
//   followed by its write-back, and busy interlocks a new read against the
//   write of the same entry.
//   Reset: every queue pair context reads as cleared (valid bits in flops,
//   cleared at once; no sweep), busy and rsp_valid go low, and the block can
//   take an item as soon as reset is released.

module rdma_write_responder
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  rwr_pkg::req_t  req,
    output logic           rsp_valid,
    output rwr_pkg::rsp_t  rsp
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    rwr_pkg::req_t     req_reg;
    rwr_pkg::rsp_t     rsp_reg;
    logic              rsp_valid_reg;
    logic              take;
    logic              exec;
    rwr_pkg::ctx_t     ctx;
    rwr_pkg::rsp_t     rsp_next;
    rwr_pkg::ctx_wr_t  ctx_wr;

    assign exec = (state_reg == ST_EXEC);
    assign busy = exec;
    assign take = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (take) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg <= req;
        end
        if (exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    rwr_ctx_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (take),
        .rd_addr (req.qp_index[rwr_pkg::QP_W-1:0]),
        .rd_data (ctx),
        .wr      (ctx_wr)
    );

    rwr_engine u_engine
    (
        .req  (req_reg),
        .ctx  (ctx),
        .exec (exec),
        .rsp  (rsp_next),
        .wr   (ctx_wr)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> busy)
        else $error("item taken without entering execute");

    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (rsp_valid && !busy))
        else $error("execute not followed by a result");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $past(busy))
        else $error("result without a prior execute cycle");

    a_wr_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ctx_wr.en |-> (busy && !rsp_next.ignored))
        else $error("context write outside execute");

    a_addr_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.write_enable) |-> (rsp.write_address == 64'd0))
        else $error("write address set without write enable");

endmodule

@@ src/rwr_ctx_store.sv @@
`timescale 1ns / 1ps
// Per-queue-pair message context memory with registered read.
// Valid bits give the cleared context for entries not yet written. Uses rwr_pkg.

module rwr_ctx_store
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [rwr_pkg::QP_W-1:0] rd_addr,
    output rwr_pkg::ctx_t            rd_data,
    input  rwr_pkg::ctx_wr_t         wr
);

    rwr_pkg::ctx_t                   mem [rwr_pkg::QP_COUNT];
    logic [rwr_pkg::QP_COUNT-1:0]    valid_reg;
    rwr_pkg::ctx_t                   rd_reg;
    logic                            rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_reg : '0;

endmodule

@@ src/rwr_engine.sv @@
`timescale 1ns / 1ps
// Header checks and context update for one write packet.
// Combinational; uses rwr_pkg types and codes.

module rwr_engine
(
    input  rwr_pkg::req_t    req,
    input  rwr_pkg::ctx_t    ctx,
    input  logic             exec,
    output rwr_pkg::rsp_t    rsp,
    output rwr_pkg::ctx_wr_t wr
);

    logic                           rc_write;
    logic                           first;
    logic                           complete;
    logic                           imm;
    logic [rwr_pkg::LEN_W-1:0]      len;
    rwr_pkg::ctx_t                  work;
    rwr_pkg::ctx_t                  upd;

    assign rc_write = (req.opcode >= rwr_pkg::OP_WR_FIRST)
                   && (req.opcode <= rwr_pkg::OP_WR_ONLY_IMM);
    assign first    = (req.opcode == rwr_pkg::OP_WR_FIRST)
                   || (req.opcode == rwr_pkg::OP_WR_ONLY)
                   || (req.opcode == rwr_pkg::OP_WR_ONLY_IMM);
    assign complete = (req.opcode == rwr_pkg::OP_WR_LAST)
                   || (req.opcode == rwr_pkg::OP_WR_LAST_IMM)
                   || (req.opcode == rwr_pkg::OP_WR_ONLY)
                   || (req.opcode == rwr_pkg::OP_WR_ONLY_IMM);
    assign imm      = (req.opcode == rwr_pkg::OP_WR_LAST_IMM)
                   || (req.opcode == rwr_pkg::OP_WR_ONLY_IMM);
    assign len      = (req.payload_length > rwr_pkg::MAX_LEN) ? rwr_pkg::MAX_LEN
                                                              : req.payload_length;

    always_comb
    begin
        work = ctx;
        if (first)
        begin
            work.active       = 1'b1;
            work.base_address = req.reth_address;
            work.byte_count   = '0;
            work.next_psn     = req.psn;
            work.imm_seen     = 1'b0;
            work.immediate    = '0;
        end
    end

    always_comb
    begin
        rsp     = '0;
        upd     = work;
        wr.en   = 1'b0;
        wr.addr = req.qp_index[rwr_pkg::QP_W-1:0];
        if (!rc_write)
        begin
            rsp.ignored = 1'b1;
        end
        else if (!req.qp_can_receive)
        begin
            rsp.ack_needed = 1'b1;
            rsp.syndrome   = rwr_pkg::SYN_INV_REQ;
            rsp.ack_psn    = req.psn;
        end
        else if (req.psn != req.qp_epsn)
        begin
            rsp.ack_needed = 1'b1;
            rsp.syndrome   = rwr_pkg::SYN_PSN_ERR;
            rsp.ack_psn    = req.qp_epsn;
        end
        else if (first && !req.reth_valid)
        begin
            rsp.ack_needed = 1'b1;
            rsp.syndrome   = rwr_pkg::SYN_INV_REQ;
            rsp.ack_psn    = req.psn;
        end
        else if (first && req.access_status[rwr_pkg::ST_KEY_REJ])
        begin
            rsp.ack_needed = 1'b1;
            rsp.syndrome   = rwr_pkg::SYN_ACC_ERR;
            rsp.ack_psn    = req.psn;
        end
        else if (!work.active)
        begin
            rsp.ack_needed = 1'b1;
            rsp.syndrome   = rwr_pkg::SYN_INV_REQ;
            rsp.ack_psn    = req.psn;
        end
        else if (!first && (work.next_psn != req.psn))
        begin
            rsp.ack_needed = 1'b1;
            rsp.syndrome   = rwr_pkg::SYN_PSN_ERR;
            rsp.ack_psn    = work.next_psn;
        end
        else if ((len != '0) && req.access_status[rwr_pkg::ST_PAY_REJ])
        begin
            // close the message
            rsp.ack_needed = 1'b1;
            rsp.syndrome   = rwr_pkg::SYN_ACC_ERR;
            rsp.ack_psn    = req.psn;
            upd.active     = 1'b0;
            wr.en          = exec;
        end
        else if (complete && imm && !req.recv_wqe_available)
        begin
            rsp.ack_needed = 1'b1;
            rsp.syndrome   = rwr_pkg::SYN_RNR_NAK;
            rsp.ack_psn    = req.psn;
        end
        else
        begin
            upd.byte_count     = work.byte_count + 32'(len);
            upd.next_psn       = req.psn + 24'd1;
            rsp.advance_qp_psn = 1'b1;
            if (len != '0)
            begin
                rsp.write_enable  = 1'b1;
                rsp.write_address = work.base_address + 64'(work.byte_count);
            end
            if (imm)
            begin
                upd.imm_seen  = 1'b1;
                upd.immediate = req.imm_word;
            end
            if (complete)
            begin
                rsp.message_complete = 1'b1;
                upd.active           = 1'b0;
                if (upd.imm_seen)
                begin
                    rsp.cqe_valid     = 1'b1;
                    rsp.cqe_bytes     = upd.byte_count;
                    rsp.cqe_immediate = upd.immediate;
                end
            end
            if (req.ack_req || complete)
            begin
                rsp.ack_needed = 1'b1;
                rsp.syndrome   = rwr_pkg::SYN_ACK;
                rsp.ack_psn    = req.psn;
            end
            rsp.accepted = 1'b1;
            wr.en        = exec;
        end
        wr.data = upd;
    end

endmodule
